>>> sv/alr_pkg.sv
// ============================================================================
// alr_pkg: shared types and constants for the ambient light lamp ramp
// Field widths, register indexes, divider widths and the divider interface.
// ============================================================================
package alr_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int LEVEL_W      = 8;
    localparam int LEVEL_CFG_W  = 11;
    localparam int INTERVAL_W   = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    localparam int AVG_SAMPLES_DEFAULT = 8;

    localparam logic [LEVEL_CFG_W-1:0] DARK_RESET     = 11'd0;
    localparam logic [LEVEL_CFG_W-1:0] BRIGHT_RESET   = 11'd1024;
    localparam logic [INTERVAL_W-1:0]  INTERVAL_RESET = 16'd10;
    localparam logic [INTERVAL_W-1:0]  TICKS_MAX      = 16'hFFFF;

    localparam logic [LEVEL_CFG_W-1:0] FULL_SCALE = 11'd1024;
    localparam logic [LEVEL_W-1:0]     LEVEL_MAX  = 8'd255;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DARK     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 2'd2;

    // Serial divider for the target: 18-bit dividend covers 255*1024, 11-bit divisor
    localparam int DIV_N_W   = 18;
    localparam int DIV_D_W   = 11;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> sv/ambient_light_lamp_ramp_top.sv
// ============================================================================
// ambient_light_lamp_ramp_top: lamp level that follows ambient light
// Moving average of sensor samples, threshold map and one-step slew limit.
// ============================================================================
// One input transaction is one millisecond tick with a 10-bit sensor sample;
// every tick returns exactly one output transaction with the lamp level after
// the tick and a flag that says whether the level stepped. The first tick
// after reset writes its sample into every entry of the averaging ring, one
// entry per cycle. A tick that arrives before the configured interval has
// passed skips the evaluation and goes straight to the output register. A
// tick that evaluates runs through these steps: the ring memory is read and
// rewritten, the mean sum / AVG_SAMPLES comes from a constant reciprocal
// multiply, the target is decided, then the one-bit-per-cycle divider works
// out 255*(A-D)/(B-D), and last the level steps and the output register is
// loaded. The division is skipped when ambient is at or below dark_level or
// bright_level is not above dark_level. A stalled output stream adds its
// stall cycles. Ticks are taken one at a time; the next tick is accepted
// while the previous result still waits in the output register.
// Write the configuration registers only while no tick is in flight.
// ============================================================================
module ambient_light_lamp_ramp_top
    import alr_pkg::*;
#(
    parameter int AVG_SAMPLES = AVG_SAMPLES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [9:0] sensor_sample, [15:10] zero
    // level stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // [7:0] lamp_level, [8] level_changed,
                                              // [15:9] zero
);

    localparam int IDX_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(AVG_SAMPLES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_SAMPLES - 1);

    // floor(sum / AVG_SAMPLES) as (sum * ceil(2^k / AVG_SAMPLES)) >> k, exact for
    // every sum below 2^SUM_W when k = SUM_W + clog2(AVG_SAMPLES)
    localparam int MEAN_SHIFT = SUM_W + $clog2(AVG_SAMPLES);
    localparam int RECIP_W    = SUM_W + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((1 << MEAN_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_FILL = 8'b00000010,
        S_READ = 8'b00000100,
        S_MEAN = 8'b00001000,
        S_EVAL = 8'b00010000,
        S_DIVT = 8'b00100000,
        S_STEP = 8'b01000000,
        S_DONE = 8'b10000000
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEVEL_CFG_W-1:0] dark_reg;
    logic [LEVEL_CFG_W-1:0] bright_reg;
    logic [INTERVAL_W-1:0]  interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg     <= DARK_RESET;
            bright_reg   <= BRIGHT_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DARK:     dark_reg     <= cfg_data[LEVEL_CFG_W-1:0];
                CFG_BRIGHT:   bright_reg   <= cfg_data[LEVEL_CFG_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic                  primed_reg, primed_next;
    logic [IDX_W-1:0]      ring_idx_reg, ring_idx_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [INTERVAL_W-1:0] ticks_reg, ticks_next;
    logic                  changed_reg, changed_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]    out_level_reg, out_level_next;
    logic                  out_changed_reg, out_changed_next;

    // payload registers
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [LEVEL_W-1:0]    target_reg, target_next;
    logic [SAMPLE_W-1:0]   mean_reg, mean_next;

    // ring memory with a registered read
    logic [SAMPLE_W-1:0]   ring_mem [AVG_SAMPLES];
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  mem_we;
    logic                  mem_re;

    div_req_t              div_req;
    div_rsp_t              div_rsp;

    logic                  in_xact;
    logic                  out_xact;
    logic                  out_free;
    logic [INTERVAL_W-1:0] ticks_inc;
    logic [SUM_W-1:0]      sum_upd;
    logic [PROD_W-1:0]     mean_prod;
    logic [LEVEL_CFG_W-1:0] mean;
    logic [LEVEL_CFG_W-1:0] ambient;
    logic [LEVEL_CFG_W-1:0] amb_over_dark;
    logic [DIV_N_W-1:0]    target_num;
    logic [IDX_W-1:0]      idx_wrap;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xact  = s_tvalid && s_tready;
    assign out_xact = out_valid_reg && m_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign ticks_inc = (ticks_reg == TICKS_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign idx_wrap  = (ring_idx_reg == IDX_LAST) ? '0 : ring_idx_reg + 1'b1;

    // drop the oldest sample, add the new one
    assign sum_upd = sum_reg - SUM_W'(rd_data_reg) + SUM_W'(sample_reg);

    // constant reciprocal multiply of the registered sum
    assign mean_prod = PROD_W'(sum_reg) * PROD_W'(MEAN_RECIP);

    // mean fits in 10 bits; ambient = 1024 - mean lies in 1..1024
    assign mean          = {1'b0, mean_reg};
    assign ambient       = FULL_SCALE - mean;
    assign amb_over_dark = ambient - dark_reg;
    // 255 * x as (x << 8) - x
    assign target_num    = (DIV_N_W'(amb_over_dark) << LEVEL_W) - DIV_N_W'(amb_over_dark);

    // ------------------------------------------------------------------
    // Divider request: target once the mean is known and a ratio is needed
    // ------------------------------------------------------------------
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = target_num;
        div_req.divisor  = bright_reg - dark_reg;
        if ((state_reg == S_EVAL) &&
            (ambient > dark_reg) && (bright_reg > dark_reg))
        begin
            div_req.start = 1'b1;
        end
    end

    alr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        primed_next      = primed_reg;
        ring_idx_next    = ring_idx_reg;
        sum_next         = sum_reg;
        level_next       = level_reg;
        ticks_next       = ticks_reg;
        changed_next     = changed_reg;
        sample_next      = sample_reg;
        target_next      = target_reg;
        mean_next        = mean_reg;
        out_valid_next   = out_xact ? 1'b0 : out_valid_reg;
        out_level_next   = out_level_reg;
        out_changed_next = out_changed_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xact)
                begin
                    sample_next  = s_tdata[SAMPLE_W-1:0];
                    changed_next = 1'b0;
                    if (!primed_reg)
                    begin
                        // first tick: sweep the ring with this sample
                        ring_idx_next = '0;
                        sum_next      = '0;
                        state_next    = S_FILL;
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                        if (ticks_inc >= interval_reg)
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_FILL:
            begin
                mem_we        = 1'b1;
                sum_next      = sum_reg + SUM_W'(sample_reg);
                ring_idx_next = idx_wrap;
                if (ring_idx_reg == IDX_LAST)
                begin
                    primed_next = 1'b1;
                    level_next  = '0;
                    ticks_next  = '0;
                    state_next  = S_DONE;
                end
            end
            S_READ:
            begin
                // oldest sample is in rd_data_reg; replace it
                mem_we        = 1'b1;
                sum_next      = sum_upd;
                ring_idx_next = idx_wrap;
                state_next    = S_MEAN;
            end
            S_MEAN:
            begin
                mean_next  = mean_prod[MEAN_SHIFT +: SAMPLE_W];
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (ambient <= dark_reg)
                begin
                    target_next = '0;
                    state_next  = S_STEP;
                end
                else if (bright_reg <= dark_reg)
                begin
                    target_next = LEVEL_MAX;
                    state_next  = S_STEP;
                end
                else
                begin
                    state_next = S_DIVT;
                end
            end
            S_DIVT:
            begin
                if (div_rsp.done)
                begin
                    target_next = (div_rsp.quotient > DIV_N_W'(LEVEL_MAX)) ?
                                  LEVEL_MAX : div_rsp.quotient[LEVEL_W-1:0];
                    state_next  = S_STEP;
                end
            end
            S_STEP:
            begin
                // move one step toward the target; restart the timer on a step
                if (target_reg != level_reg)
                begin
                    level_next   = (target_reg > level_reg) ? level_reg + 1'b1 :
                                                              level_reg - 1'b1;
                    ticks_next   = '0;
                    changed_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_level_next   = level_reg;
                    out_changed_next = changed_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            primed_reg    <= 1'b0;
            ring_idx_reg  <= '0;
            sum_reg       <= '0;
            level_reg     <= '0;
            ticks_reg     <= '0;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            ring_idx_reg  <= ring_idx_next;
            sum_reg       <= sum_next;
            level_reg     <= level_next;
            ticks_reg     <= ticks_next;
            changed_reg   <= changed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg      <= sample_next;
        target_reg      <= target_next;
        mean_reg        <= mean_next;
        out_level_reg   <= out_level_next;
        out_changed_reg <= out_changed_next;
    end

    // ring memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[ring_idx_reg] <= sample_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[ring_idx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_changed_reg, out_level_reg});

endmodule

>>> sv/alr_div.sv
// ============================================================================
// alr_div: serial restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ============================================================================
module alr_div
    import alr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_N_W-1:0]   dvd_reg;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W:0]     rem_diff;
    logic                 q_bit;

    assign rem_sh   = {rem_reg, dvd_reg[DIV_N_W-1]};
    assign rem_diff = rem_sh - {1'b0, dsr_reg};
    assign q_bit    = (rem_sh >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_reg <= q_bit ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            dvd_reg <= {dvd_reg[DIV_N_W-2:0], q_bit};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

>>> sv/alr_checker.sv
// ============================================================================
// alr_checker: port-level checks for the ambient light lamp ramp
// Watches both streams: stall behavior, padding and the one-step slew.
// ============================================================================
module alr_checker
    import alr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [S_TDATA_W-1:0]   s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_TDATA_W-1:0]   m_tdata
);

    logic               have_last_reg;
    logic [LEVEL_W-1:0] last_level_reg;
    logic               out_xact;
    logic [LEVEL_W-1:0] level;
    logic               changed;

    assign out_xact = m_tvalid && m_tready;
    assign level    = m_tdata[LEVEL_W-1:0];
    assign changed  = m_tdata[LEVEL_W];

    // remember the level of the last delivered transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_last_reg  <= 1'b0;
            last_level_reg <= '0;
        end
        else if (out_xact)
        begin
            have_last_reg  <= 1'b1;
            last_level_reg <= level;
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input transaction dropped or changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction dropped or changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:LEVEL_W+1] == '0))
        else $error("output padding bits not zero");

    a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_xact && have_last_reg && changed |->
            ({1'b0, level} == {1'b0, last_level_reg} + 1'b1) ||
            ({1'b0, level} + 1'b1 == {1'b0, last_level_reg}))
        else $error("level stepped by more than one");

    a_no_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_xact && have_last_reg && !changed |-> level == last_level_reg)
        else $error("level moved without level_changed");

endmodule

bind ambient_light_lamp_ramp_top alr_checker u_alr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/tb_ambient_light_lamp_ramp_top.sv
// ============================================================================
// tb_ambient_light_lamp_ramp_top: self-checking bench for the lamp ramp
// Drives sensor ticks on the sample stream, predicts the lamp level of every
// tick with a local model of the ring average, target map and slew step, and
// compares each level transaction against the oldest prediction. Runs a short
// directed sequence, then several register settings with random light
// profiles and random idling on both streams after the first setting.
// ============================================================================
`timescale 1ns / 100ps

module tb_ambient_light_lamp_ramp_top;

    import alr_pkg::*;

    localparam int RING_DEPTH   = AVG_SAMPLES_DEFAULT;
    localparam int DRAIN_CYCLES = 48;
    localparam int IDLE_PCT     = 36;
    localparam int NUM_PHASES   = 12;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               changed;
    } lamp_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: owns the lamp predictor and the queue of predicted levels.
    // ------------------------------------------------------------------------
    class lamp_scoreboard;
        logic [SAMPLE_W-1:0]    ring [RING_DEPTH];
        int unsigned            slot;
        int unsigned            sum;
        logic [LEVEL_W-1:0]     level;
        logic [INTERVAL_W-1:0]  ticks;
        bit                     primed;
        logic [LEVEL_CFG_W-1:0] dark;
        logic [LEVEL_CFG_W-1:0] bright;
        logic [INTERVAL_W-1:0]  interval;
        lamp_result_t           predicted_levels [$];
        int                     errors;
        int                     ticks_seen;
        int                     levels_seen;
        int                     steps_seen;

        function new();
            for (int i = 0; i < RING_DEPTH; i++)
                ring[i] = '0;
            slot        = 0;
            sum         = 0;
            level       = '0;
            ticks       = '0;
            primed      = 0;
            dark        = DARK_RESET;
            bright      = BRIGHT_RESET;
            interval    = INTERVAL_RESET;
            errors      = 0;
            ticks_seen  = 0;
            levels_seen = 0;
            steps_seen  = 0;
        endfunction

        // Registers keep only their own width of the write data
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DARK:     dark     = data[LEVEL_CFG_W-1:0];
                CFG_BRIGHT:   bright   = data[LEVEL_CFG_W-1:0];
                CFG_INTERVAL: interval = data[INTERVAL_W-1:0];
                default:      ;
            endcase
        endfunction

        function int unsigned target_for(int unsigned amb);
            int unsigned q;
            if (amb <= dark)
                return 0;
            if (bright <= dark)
                return LEVEL_MAX;
            q = (LEVEL_MAX * (amb - dark)) / (bright - dark);
            return (q > LEVEL_MAX) ? LEVEL_MAX : q;
        endfunction

        // Advance the lamp model by one accepted tick and queue its level
        function void note_tick(logic [SAMPLE_W-1:0] smp);
            lamp_result_t res;
            int unsigned  amb;
            int unsigned  tgt;
            res.changed = 1'b0;
            ticks_seen++;
            if (!primed) begin
                for (int i = 0; i < RING_DEPTH; i++)
                    ring[i] = smp;
                sum    = smp * RING_DEPTH;
                slot   = 0;
                level  = '0;
                ticks  = '0;
                primed = 1;
            end
            else begin
                if (ticks != TICKS_MAX)
                    ticks++;
                if (ticks >= interval) begin
                    sum        = sum - ring[slot] + smp;
                    ring[slot] = smp;
                    slot       = (slot + 1) % RING_DEPTH;
                    amb        = FULL_SCALE - sum / RING_DEPTH;
                    tgt        = target_for(amb);
                    if (tgt != level) begin
                        if (tgt > level)
                            level++;
                        else
                            level--;
                        ticks       = '0;
                        res.changed = 1'b1;
                        steps_seen++;
                    end
                end
            end
            res.level = level;
            predicted_levels.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            lamp_result_t exp_res;
            levels_seen++;
            if (predicted_levels.size() == 0) begin
                $display("%0t: unexpected level transaction, actual level %0d changed %0b",
                         $time, tdata[7:0], tdata[8]);
                errors++;
                return;
            end
            exp_res = predicted_levels.pop_front();
            if (tdata[7:0] !== exp_res.level) begin
                $display("%0t: lamp_level mismatch, expected %0d actual %0d",
                         $time, exp_res.level, tdata[7:0]);
                errors++;
            end
            if (tdata[8] !== exp_res.changed) begin
                $display("%0t: level_changed mismatch, expected %0b actual %0b",
                         $time, exp_res.changed, tdata[8]);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_levels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // [9:0] sensor_sample, [15:10] zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // [7:0] lamp_level, [8] level_changed, [15:9] zero

    lamp_scoreboard         board;
    bit                     calm;        // suppress idling on both streams
    int                     light_base;  // slowly wandering ambient light
    int                     phases_run;

    // Register settings of the random part: dark, bright, interval, tick count.
    // Writes with bits above the register width check the masking.
    logic [CFG_DATA_W-1:0] ph_dark     [NUM_PHASES] = '{16'd0, 16'd0, 16'd200, 16'd600,
        16'd500, 16'd1024, 16'd0, 16'hFFFF, 16'd100, 16'd0, 16'd300, 16'd0};
    logic [CFG_DATA_W-1:0] ph_bright   [NUM_PHASES] = '{16'd1024, 16'd1024, 16'd800,
        16'd300, 16'd500, 16'd1024, 16'h07FF, 16'hF800, 16'd900, 16'd16, 16'd700, 16'd1024};
    logic [CFG_DATA_W-1:0] ph_interval [NUM_PHASES] = '{16'd0, 16'd1, 16'd2, 16'd0,
        16'd1, 16'd0, 16'd0, 16'd0, 16'd5, 16'd0, 16'hFFFF, 16'd10};
    int                    ph_count    [NUM_PHASES] = '{70, 60, 60, 50, 40, 50, 60, 30,
        60, 60, 12, 60};

    ambient_light_lamp_ramp_top #(
        .AVG_SAMPLES (RING_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: stall at random on the falling edge unless in a calm stretch
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Level monitor: every accepted level transaction goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // Pick the next sensor sample: mostly a noisy steady light so the average
    // settles and the level can ramp into its target, with jumps and extremes
    // mixed in.
    function logic [SAMPLE_W-1:0] next_sample();
        int pick;
        int val;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 4)
            light_base = $urandom_range(0, 1023);
        if (pick < 60)
            val = light_base + $urandom_range(0, 16) - 8;
        else if (pick < 80)
            val = $urandom_range(0, 1023);
        else if (pick < 90)
            val = $urandom_range(0, 1) ? 1023 : 0;
        else
            val = light_base;
        if (val < 0)
            val = 0;
        if (val > 1023)
            val = 1023;
        return val[SAMPLE_W-1:0];
    endfunction

    // Offer one tick: idle at random, then hold valid until the transaction
    task automatic send_tick(input logic [SAMPLE_W-1:0] smp);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W-SAMPLE_W){1'b0}}, smp};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_tick(smp);
    endtask

    // Drop valid and wait until every predicted level has been seen
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write on the falling edge; the block takes it at the next rise
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        board.write_reg(idx, data);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] d,
                            input logic [CFG_DATA_W-1:0] b,
                            input logic [CFG_DATA_W-1:0] ivl);
        settle();
        write_reg(CFG_DARK, d);
        write_reg(CFG_BRIGHT, b);
        write_reg(CFG_INTERVAL, ivl);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board      = new();
        calm       = 1'b0;
        light_base = 512;
        phases_run = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_DARK;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: the first tick primes the ring, the next nine fall
        // short of the interval and the eleventh evaluates.
        send_tick(10'd0);
        send_tick(10'd1023);
        send_tick(10'h155);
        send_tick(10'h2AA);
        send_tick(10'd0);
        send_tick(10'd1023);
        repeat (5) send_tick(10'd0);

        // Zero interval: every tick evaluates, level steps up on each tick
        set_regs(16'd0, 16'd1024, 16'd0);
        send_tick(10'd1023);
        send_tick(10'd1023);
        repeat (3) send_tick(10'd0);

        // Bright below dark: target is all or nothing around dark
        set_regs(16'd600, 16'd300, 16'd0);
        send_tick(10'd0);
        repeat (2) send_tick(10'd1023);

        // All-ones writes: dark and bright at their masked maximum, so the
        // target stays at zero and a level at zero holds without a step
        set_regs(16'hFFFF, 16'hFFFF, 16'd3);
        send_tick(10'd1023);
        send_tick(10'd0);
        send_tick(10'h3FF);
        send_tick(10'd0);

        // Random part, one pass per register setting; the first one runs
        // without idling on either stream
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_regs(ph_dark[p], ph_bright[p], ph_interval[p]);
            calm = (p == 0);
            for (int n = 0; n < ph_count[p]; n++)
                send_tick(next_sample());
            phases_run++;
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d ticks over %0d random register settings plus directed cases,",
                 board.ticks_seen, phases_run);
        $display("checked %0d level transactions, %0d of them level steps.",
                 board.levels_seen, board.steps_seen);
        if (board.errors == 0)
            $display("tb_ambient_light_lamp_ramp_top: PASS");
        else
            $display("tb_ambient_light_lamp_ramp_top: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d level transactions still outstanding", board.pending());
        $display("tb_ambient_light_lamp_ramp_top: FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/alr_pkg.sv
sv/alr_div.sv
sv/ambient_light_lamp_ramp_top.sv
sv/alr_checker.sv
verif/tb_ambient_light_lamp_ramp_top.sv
